[rtl/btkh_pkg.sv]
package btkh_pkg;

  localparam int unsigned SCORE_BITS = 32;
  localparam int unsigned TAG_BITS   = 16;
  localparam int unsigned CNT_BITS   = 7;
  localparam int unsigned CAP_BITS   = 7;

  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;

  localparam logic [CAP_BITS-1:0] CAP_RESET = 7'd10;

  // register index taken from paddr[2]
  localparam logic REG_CAPACITY = 1'b0;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_REPLACED  = 3'd1,
    ST_DROPPED   = 3'd2,
    ST_POPPED    = 3'd3,
    ST_POP_EMPTY = 3'd4
  } status_e;

  typedef struct packed {
    logic                         opcode;
    logic signed [SCORE_BITS-1:0] item_score;
    logic [TAG_BITS-1:0]          item_tag;
  } in_item_t;

  typedef struct packed {
    status_e                      status;
    logic signed [SCORE_BITS-1:0] out_score;
    logic [TAG_BITS-1:0]          out_tag;
    logic [CNT_BITS-1:0]          entry_total;
    logic signed [SCORE_BITS-1:0] min_score;
  } out_item_t;

  typedef struct packed {
    logic signed [SCORE_BITS-1:0] score;
    logic [TAG_BITS-1:0]          tag;
  } entry_t;

endpackage

[rtl/btkh_cfg.sv]
module btkh_cfg
  import btkh_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 64,
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [CW-1:0]         eff_cap_o
);

  localparam int unsigned EW = (CW > CAP_BITS) ? CW : CAP_BITS;

  logic [CAP_BITS-1:0] cap_q, cap_d;
  logic [EW-1:0]       cap_ext;
  logic [EW-1:0]       cap_clip;
  logic                wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);

  always_comb begin
    cap_d = cap_q;
    if (wr_en) begin
      cap_d = pwdata[CAP_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else begin
      cap_q <= cap_d;
    end
  end

  assign prdata = (paddr[2] == REG_CAPACITY) ? APB_DATA_W'(cap_q) : '0;

  // zero behaves as one, anything past the memory depth as the depth
  always_comb begin
    cap_ext = EW'(cap_q);
    if (cap_ext == '0) begin
      cap_clip = EW'(1);
    end else if (cap_ext > EW'(MAX_ENTRIES)) begin
      cap_clip = EW'(MAX_ENTRIES);
    end else begin
      cap_clip = cap_ext;
    end
  end

  assign eff_cap_o = cap_clip[CW-1:0];

endmodule

[rtl/bounded_top_k_min_heap_core.sv]
// Bounded top-K min-heap. Keeps up to "capacity" scored items in a binary
// min-heap held in one synchronous RAM (two read ports, one write port).
//
// Input channel (in_valid_i / in_stall_o / in_data_i): a transfer carries a
// push (score, tag) or a pop. Output channel (out_valid_o / out_stall_i /
// out_data_o): exactly one result per input item, in order.
// The capacity register sits at byte address 0 of the APB port; write it
// only while the block is idle.
//
// Path from input transfer to result valid: a drop or an empty pop goes
// straight to the done state. An insert alternates a parent read and a
// write for each level it climbs; a sift down alternates a child read and
// a write for each level it descends, and a pop first reads the last entry.
// One item is worked on at a time; in_stall_o is low only when the engine
// is idle.
//
// Reset empties the heap and sets capacity to 10; RAM contents are not
// cleared. While out_stall_i holds, the finished result waits in the
// output register and the next item may still be taken and processed;
// that item's result then waits in the engine until the register frees.
module bounded_top_k_min_heap_core
  import btkh_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_data_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned AW = $clog2(MAX_ENTRIES);
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned XW = AW + 2;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SUP_R = 3'd1;
  localparam logic [2:0] S_SUP_W = 3'd2;
  localparam logic [2:0] S_POP_L = 3'd3;
  localparam logic [2:0] S_SDN_R = 3'd4;
  localparam logic [2:0] S_SDN_W = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] held_q, held_d;
  logic [AW-1:0] hole_q, hole_d;
  entry_t        mov_q, mov_d;
  entry_t        root_q;
  status_e       status_q, status_d;
  entry_t        res_q, res_d;
  logic          out_valid_q, out_valid_d;
  out_item_t     out_q, out_d;

  logic [CW-1:0] eff_cap;
  logic          accept;
  logic          out_free;

  // heap RAM
  entry_t        mem_q [MAX_ENTRIES];
  entry_t        rda_q, rdb_q;
  logic [AW-1:0] ra, rb, wa;
  logic          we;
  entry_t        wd;

  logic [AW-1:0] par_idx;
  logic [XW-1:0] lc_x, rc_x, n_x;
  logic          take_l, take_r;
  entry_t        cand;

  btkh_cfg #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .eff_cap_o(eff_cap)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign par_idx = (hole_q - AW'(1)) >> 1;
  assign lc_x    = XW'({hole_q, 1'b1});
  assign rc_x    = lc_x + XW'(1);
  assign n_x     = XW'(held_q);

  // child selection: left wins a tie, swap only on strictly smaller
  assign take_l = (rda_q.score < mov_q.score);
  assign cand   = take_l ? rda_q : mov_q;
  assign take_r = (rc_x < n_x) && (rdb_q.score < cand.score);

  always_comb begin
    state_d  = state_q;
    held_d   = held_q;
    hole_d   = hole_q;
    mov_d    = mov_q;
    status_d = status_q;
    res_d    = res_q;
    ra       = par_idx;
    rb       = rc_x[AW-1:0];
    we       = 1'b0;
    wa       = hole_q;
    wd       = mov_q;
    out_d    = out_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          mov_d.score = in_data_i.item_score;
          mov_d.tag   = in_data_i.item_tag;
          if (in_data_i.opcode == OP_PUSH) begin
            if (held_q < eff_cap) begin
              status_d = ST_INSERTED;
              res_d    = '0;
              hole_d   = held_q[AW-1:0];
              held_d   = held_q + CW'(1);
              state_d  = S_SUP_R;
            end else if (in_data_i.item_score < root_q.score) begin
              status_d     = ST_DROPPED;
              res_d.score  = in_data_i.item_score;
              res_d.tag    = in_data_i.item_tag;
              state_d      = S_DONE;
            end else begin
              status_d = ST_REPLACED;
              res_d    = root_q;
              hole_d   = '0;
              state_d  = S_SDN_R;
            end
          end else begin
            if (held_q == '0) begin
              status_d = ST_POP_EMPTY;
              res_d    = '0;
              state_d  = S_DONE;
            end else begin
              status_d = ST_POPPED;
              res_d    = root_q;
              held_d   = held_q - CW'(1);
              hole_d   = '0;
              ra       = AW'(held_q - CW'(1));
              state_d  = S_POP_L;
            end
          end
        end
      end
      S_SUP_R: begin
        if (hole_q == '0) begin
          we      = 1'b1;
          state_d = S_DONE;
        end else begin
          state_d = S_SUP_W;
        end
      end
      S_SUP_W: begin
        we = 1'b1;
        if (rda_q.score > mov_q.score) begin
          wd      = rda_q;
          hole_d  = par_idx;
          state_d = S_SUP_R;
        end else begin
          state_d = S_DONE;
        end
      end
      S_POP_L: begin
        mov_d = rda_q;
        if (held_q == '0) begin
          state_d = S_DONE;
        end else begin
          state_d = S_SDN_R;
        end
      end
      S_SDN_R: begin
        ra = lc_x[AW-1:0];
        if (lc_x >= n_x) begin
          we      = 1'b1;
          state_d = S_DONE;
        end else begin
          state_d = S_SDN_W;
        end
      end
      S_SDN_W: begin
        we = 1'b1;
        if (take_r) begin
          wd      = rdb_q;
          hole_d  = rc_x[AW-1:0];
          state_d = S_SDN_R;
        end else if (take_l) begin
          wd      = rda_q;
          hole_d  = lc_x[AW-1:0];
          state_d = S_SDN_R;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_d.status      = status_q;
          out_d.out_score   = res_q.score;
          out_d.out_tag     = res_q.tag;
          out_d.entry_total = CNT_BITS'(held_q);
          out_d.min_score   = (held_q != '0) ? root_q.score : '0;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = ((state_q == S_DONE) && out_free) || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      held_q      <= '0;
      hole_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      held_q      <= held_d;
      hole_q      <= hole_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mov_q    <= mov_d;
    status_q <= status_d;
    res_q    <= res_d;
    out_q    <= out_d;
    // root mirror tracks every write to entry zero
    if (we && (wa == '0)) begin
      root_q <= wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    rda_q <= mem_q[ra];
    rdb_q <= mem_q[rb];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= CW'(MAX_ENTRIES))
    else $error("held count past memory depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result raised outside done state");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SDN_W && (take_l || take_r)) |=> (hole_q > $past(hole_q)))
    else $error("sift down did not move toward leaves");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |=> (held_q == $past(held_q)))
    else $error("held count changed mid operation");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SUP_W && rda_q.score > mov_q.score) |=> (hole_q < $past(hole_q)))
    else $error("sift up did not move toward root");

endmodule

[bench/heap_checker.sv]
`timescale 1ns / 100ps

module heap_checker
  import btkh_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  in_item_t              in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  out_item_t             out_data_i,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  input  logic                  pready,
  output int unsigned           error_count_o,
  output int unsigned           pending_o
);

  // shadow heap, same layout as the block keeps it
  logic signed [SCORE_BITS-1:0] score_mem [MAX_ENTRIES];
  logic [TAG_BITS-1:0]          tag_mem   [MAX_ENTRIES];
  int unsigned                  held;
  logic [CAP_BITS-1:0]          cap_reg;
  out_item_t                    awaited_q [$];
  int unsigned                  err_count = 0;

  function automatic int unsigned cap_limit();
    if (cap_reg == '0) return 1;
    if (cap_reg > MAX_ENTRIES) return MAX_ENTRIES;
    return cap_reg;
  endfunction

  task automatic swap_slots(input int unsigned a, input int unsigned b);
    logic signed [SCORE_BITS-1:0] s;
    logic [TAG_BITS-1:0]          t;
    s = score_mem[a]; score_mem[a] = score_mem[b]; score_mem[b] = s;
    t = tag_mem[a];   tag_mem[a]   = tag_mem[b];   tag_mem[b]   = t;
  endtask

  // strict compares only; left child wins a tie between children
  task automatic sink_root();
    int unsigned pos;
    int unsigned lc;
    int unsigned rc;
    int unsigned best;
    pos = 0;
    while (pos < held) begin
      lc   = 2 * pos + 1;
      rc   = lc + 1;
      best = pos;
      if (lc >= held) break;
      if (score_mem[lc] < score_mem[best]) best = lc;
      if (rc < held && score_mem[rc] < score_mem[best]) best = rc;
      if (best == pos) break;
      swap_slots(pos, best);
      pos = best;
    end
  endtask

  task automatic predict_heap_op(input in_item_t it, output out_item_t res);
    int unsigned pos;
    int unsigned up;
    res = '0;
    if (it.opcode == OP_PUSH) begin
      if (held < cap_limit()) begin
        score_mem[held] = it.item_score;
        tag_mem[held]   = it.item_tag;
        pos  = held;
        held = held + 1;
        while (pos > 0) begin
          up = (pos - 1) / 2;
          if (score_mem[up] > score_mem[pos]) begin
            swap_slots(up, pos);
            pos = up;
          end else begin
            break;
          end
        end
        res.status = ST_INSERTED;
      end else if (it.item_score < score_mem[0]) begin
        res.status    = ST_DROPPED;
        res.out_score = it.item_score;
        res.out_tag   = it.item_tag;
      end else begin
        res.status    = ST_REPLACED;
        res.out_score = score_mem[0];
        res.out_tag   = tag_mem[0];
        score_mem[0]  = it.item_score;
        tag_mem[0]    = it.item_tag;
        sink_root();
      end
    end else if (held == 0) begin
      res.status = ST_POP_EMPTY;
    end else begin
      res.status    = ST_POPPED;
      res.out_score = score_mem[0];
      res.out_tag   = tag_mem[0];
      score_mem[0]  = score_mem[held - 1];
      tag_mem[0]    = tag_mem[held - 1];
      held          = held - 1;
      sink_root();
    end
    res.entry_total = CNT_BITS'(held);
    res.min_score   = (held != 0) ? score_mem[0] : '0;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      err_count = err_count + 1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_item_t want;
    out_item_t next_res;
    if (!rst_ni) begin
      held    = 0;
      cap_reg = CAP_RESET;
      awaited_q.delete();
    end else begin
      // a result always belongs to an earlier transfer, so check it first
      if (out_valid_i && !out_stall_i) begin
        if (awaited_q.size() == 0) begin
          $display("%0t: result with nothing expected, expected none, got %h",
                   $time, out_data_i);
          err_count = err_count + 1;
        end else begin
          want = awaited_q.pop_front();
          check_field("status", 32'(want.status), 32'(out_data_i.status));
          check_field("out_score", want.out_score, out_data_i.out_score);
          check_field("out_tag", 32'(want.out_tag), 32'(out_data_i.out_tag));
          check_field("entry_total", 32'(want.entry_total), 32'(out_data_i.entry_total));
          check_field("min_score", want.min_score, out_data_i.min_score);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predict_heap_op(in_data_i, next_res);
        awaited_q = {awaited_q, next_res};
      end
      if (psel && penable && pwrite && pready && paddr[2] == REG_CAPACITY)
        cap_reg = pwdata[CAP_BITS-1:0];
    end
    error_count_o <= err_count;
    pending_o     <= awaited_q.size();
  end

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import btkh_pkg::*;

  localparam int unsigned MAX_ENTRIES = 64;
  localparam int unsigned HOLD_CYCLES = 150;

  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [APB_ADDR_W-1:0] paddr     = '0;
  logic [APB_DATA_W-1:0] pwdata    = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int unsigned error_count;
  int unsigned pending;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned hold_req      = 0;
  int unsigned hold_seen     = 0;
  int unsigned hold_left     = 0;

  always #1 clk_i = ~clk_i;

  bounded_top_k_min_heap_core #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  heap_checker #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .error_count_o(error_count),
    .pending_o    (pending)
  );

  // receiver: random stall, or a long hold-off when one is requested
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_seen <= 0;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk_i); while (in_stall);
  endtask

  task automatic push_op(input logic [SCORE_BITS-1:0] score, input logic [TAG_BITS-1:0] tag);
    in_item_t it;
    it.opcode     = OP_PUSH;
    it.item_score = score;
    it.item_tag   = tag;
    send_item(it);
  endtask

  task automatic pop_op();
    in_item_t it;
    it.opcode     = OP_POP;
    it.item_score = $urandom;
    it.item_tag   = TAG_BITS'($urandom);
    send_item(it);
  endtask

  task automatic random_ops(input int unsigned count, input int unsigned push_pct);
    in_item_t it;
    repeat (count) begin
      it.opcode = ($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP;
      case ($urandom_range(9))
        0:       it.item_score = 32'h7FFF_FFFF;
        1:       it.item_score = 32'h8000_0000;
        2, 3, 4: it.item_score = SCORE_BITS'(int'($urandom_range(16)) - 8); // ties
        default: it.item_score = $urandom;
      endcase
      it.item_tag = TAG_BITS'($urandom);
      send_item(it);
    end
  endtask

  // every item yields one result, so an empty queue means the block is idle
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CAP_BITS-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_CAPACITY, 2'b00};
    pwdata  <= APB_DATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_idle(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    stall_pct    <= recv_pct;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, at the reset capacity of 10
    pop_op();
    push_op(32'h7FFF_FFFF, 16'hFFFF);
    push_op(32'h8000_0000, 16'h0000);
    push_op(32'h0000_0000, 16'h1234);
    push_op(32'h0000_0000, 16'h4321);
    push_op(32'hFFFF_FFFF, 16'hAAAA);
    push_op(32'h0001_0000, 16'h5555);
    push_op(32'h0000_8000, 16'h0F0F);
    push_op(32'hFFFF_0000, 16'hF0F0);
    push_op(32'h8000_0001, 16'h00FF);
    push_op(32'h0000_0001, 16'hFF00);
    push_op(32'h8000_0000, 16'h0001);   // equal to root: replaces it
    pop_op();
    push_op(32'h7FFF_FFFF, 16'h0003);   // fills the heap again
    push_op(32'h8000_0000, 16'h0002);   // below root: dropped
    repeat (9) pop_op();
    pop_op();                           // empty again
    wait_drained();

    write_capacity(7'd64);
    set_idle(0, 0);
    random_ops(140, 75);
    wait_drained();

    write_capacity(7'd127);
    set_idle(69, 0);
    random_ops(90, 60);
    wait_drained();

    // capacity below the held count; receiver holds off while items keep coming
    write_capacity(7'd3);
    set_idle(0, 69);
    hold_req <= hold_req + 1;
    random_ops(90, 70);
    wait_drained();

    write_capacity(7'd0);
    set_idle(26, 26);
    random_ops(80, 50);
    wait_drained();

    write_capacity(7'd1);
    set_idle(0, 0);
    random_ops(60, 35);
    wait_drained();

    write_capacity(7'd20);
    set_idle(26, 26);
    random_ops(80, 30);
    wait_drained();

    write_capacity(CAP_BITS'($urandom_range(127, 1)));
    set_idle(69, 69);
    random_ops(90, 55);
    wait_drained();

    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule
